// ----- hw/rtl/vector2_accumulator_polar_top_macros.svh -----
`ifndef VECTOR2_ACCUMULATOR_POLAR_TOP_MACROS_SVH
`define VECTOR2_ACCUMULATOR_POLAR_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define VAP_ASSERT_NOW(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define VAP_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/vap_pkg.sv -----
package vap_pkg;

    localparam int FRAC_BITS_DEF    = 16;
    localparam int CORDIC_STEPS_DEF = 24;
    localparam int GUARD_BITS       = 24;
    localparam int DATA_W           = 32;
    localparam int ANGLE_W          = 9;
    localparam int OP_W             = 3;
    localparam int TURN_W           = 32;
    // coordinate plus guard bits plus headroom for gain and sqrt(2)
    localparam int CORDIC_W         = DATA_W + GUARD_BITS + 2;
    localparam int QUEUE_DEPTH      = 2;

    localparam logic [OP_W-1:0] OP_LOAD  = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD   = 3'd1;
    localparam logic [OP_W-1:0] OP_SUB   = 3'd2;
    localparam logic [OP_W-1:0] OP_SCALE = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR = 3'd4;
    localparam logic [OP_W-1:0] OP_READ  = 3'd5;

    localparam logic [31:0]        INV_GAIN_Q32  = 32'd2608131496;
    localparam logic [TURN_W-1:0]  HALF_TURN     = 32'h8000_0000;
    localparam logic [ANGLE_W-1:0] FULL_TURN_DEG = 9'd360;
    localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic                     sat;
    } vec_item_t;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [TURN_W-1:0] atan_turns(input logic [4:0] idx);
        logic [TURN_W-1:0] r;
        case (idx)
            5'd0:  r = 32'h20000000;
            5'd1:  r = 32'h12E4051E;
            5'd2:  r = 32'h09FB385B;
            5'd3:  r = 32'h051111D4;
            5'd4:  r = 32'h028B0D43;
            5'd5:  r = 32'h0145D7E1;
            5'd6:  r = 32'h00A2F61E;
            5'd7:  r = 32'h00517C55;
            5'd8:  r = 32'h0028BE53;
            5'd9:  r = 32'h00145F2F;
            5'd10: r = 32'h000A2F98;
            5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6;
            5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2FA;
            5'd15: r = 32'h0000517D;
            5'd16: r = 32'h000028BE;
            5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A30;
            5'd19: r = 32'h00000518;
            5'd20: r = 32'h0000028C;
            5'd21: r = 32'h00000146;
            5'd22: r = 32'h000000A3;
            5'd23: r = 32'h00000051;
            5'd24: r = 32'h00000029;
            5'd25: r = 32'h00000014;
            5'd26: r = 32'h0000000A;
            5'd27: r = 32'h00000005;
            5'd28: r = 32'h00000003;
            5'd29: r = 32'h00000001;
            5'd30: r = 32'h00000001;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage

// ----- hw/rtl/vap_if.sv -----
interface vap_in_if;
    logic                                  valid;
    logic                                  ready;
    logic [vap_pkg::OP_W-1:0]              operation;
    logic signed [vap_pkg::DATA_W-1:0]     operand_x;
    logic signed [vap_pkg::DATA_W-1:0]     operand_y;
    logic signed [vap_pkg::DATA_W-1:0]     scale_factor;

    modport source (output valid, operation, operand_x, operand_y, scale_factor, input ready);
    modport sink   (input valid, operation, operand_x, operand_y, scale_factor, output ready);
endinterface

interface vap_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [vap_pkg::DATA_W-1:0]     vec_x;
    logic signed [vap_pkg::DATA_W-1:0]     vec_y;
    logic [vap_pkg::DATA_W-1:0]            magnitude;
    logic [vap_pkg::ANGLE_W-1:0]           angle_degrees;
    logic                                  saturated;

    modport source (output valid, vec_x, vec_y, magnitude, angle_degrees, saturated,
                    input ready);
    modport sink   (input valid, vec_x, vec_y, magnitude, angle_degrees, saturated,
                    output ready);
endinterface

// ----- hw/rtl/vector2_accumulator_polar_top.sv -----
// path: an accepted transaction is pushed into the queue; the back end pops it, runs the CORDIC
// iterations, then B_MLO, B_MHI, B_DEG and B_FIN to the result register; scale first passes
// F_MULX and F_MULY for each coordinate's multiply and F_PUSH to round; the back end takes a new
// transaction only after the last result is written; a two-entry queue decouples the accumulator front end
// reset: rst_n asynchronous active low, clears the vector to zero and empties queue and output
module vector2_accumulator_polar_top #(
    parameter int FRAC_BITS    = vap_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = vap_pkg::CORDIC_STEPS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    vap_in_if.sink      cmd,
    vap_out_if.source   res
);

    logic               push;
    logic               pop;
    logic               full;
    logic               empty;
    vap_pkg::vec_item_t push_item;
    vap_pkg::vec_item_t pop_item;

    vap_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .full      (full),
        .push      (push),
        .push_item (push_item)
    );

    vap_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .pop_item  (pop_item),
        .empty     (empty)
    );

    vap_back #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .empty    (empty),
        .pop_item (pop_item),
        .pop      (pop),
        .res      (res)
    );

endmodule

// ----- hw/rtl/vap_front.sv -----
module vap_front #(
    parameter int FRAC_BITS = vap_pkg::FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    vap_in_if.sink              cmd,
    input  logic                full,
    output logic                push,
    output vap_pkg::vec_item_t  push_item
);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_MULX = 2'd1;
    localparam logic [1:0] F_MULY = 2'd2;
    localparam logic [1:0] F_PUSH = 2'd3;
    localparam logic signed [63:0] ROUND_HALF = 64'sd1 <<< (FRAC_BITS - 1);

    logic [1:0] state_reg, state_next;
    logic signed [vap_pkg::DATA_W-1:0] acc_x_reg, acc_x_next;
    logic signed [vap_pkg::DATA_W-1:0] acc_y_reg, acc_y_next;
    logic signed [vap_pkg::DATA_W-1:0] sf_reg;
    logic signed [63:0] px_reg, py_reg;
    logic signed [63:0] prod_x, prod_y;
    logic signed [63:0] rnd_x, rnd_y, shr_x, shr_y;
    logic [32:0] sum_x, sum_y, dif_x, dif_y;
    logic accept;

    assign cmd.ready = (state_reg == F_IDLE) && !full;
    assign accept    = cmd.valid && cmd.ready;

    assign sum_x = {acc_x_reg[31], acc_x_reg} + {cmd.operand_x[31], cmd.operand_x};
    assign sum_y = {acc_y_reg[31], acc_y_reg} + {cmd.operand_y[31], cmd.operand_y};
    assign dif_x = {acc_x_reg[31], acc_x_reg} - {cmd.operand_x[31], cmd.operand_x};
    assign dif_y = {acc_y_reg[31], acc_y_reg} - {cmd.operand_y[31], cmd.operand_y};

    assign prod_x = acc_x_reg * sf_reg;
    assign prod_y = acc_y_reg * sf_reg;

    // round half up, then floor shift
    assign rnd_x = px_reg + ROUND_HALF;
    assign rnd_y = py_reg + ROUND_HALF;
    assign shr_x = rnd_x >>> FRAC_BITS;
    assign shr_y = rnd_y >>> FRAC_BITS;

    always_comb
    begin
        state_next = state_reg;
        acc_x_next = acc_x_reg;
        acc_y_next = acc_y_reg;
        push       = 1'b0;
        push_item  = '0;
        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    push = 1'b1;
                    case (cmd.operation)
                        vap_pkg::OP_LOAD:
                        begin
                            acc_x_next = cmd.operand_x;
                            acc_y_next = cmd.operand_y;
                        end
                        vap_pkg::OP_ADD:
                        begin
                            if (sum_x[32] != sum_x[31])
                            begin
                                acc_x_next    = sum_x[32] ? vap_pkg::S32_MIN : vap_pkg::S32_MAX;
                                push_item.sat = 1'b1;
                            end
                            else
                            begin
                                acc_x_next = sum_x[31:0];
                            end
                            if (sum_y[32] != sum_y[31])
                            begin
                                acc_y_next    = sum_y[32] ? vap_pkg::S32_MIN : vap_pkg::S32_MAX;
                                push_item.sat = 1'b1;
                            end
                            else
                            begin
                                acc_y_next = sum_y[31:0];
                            end
                        end
                        vap_pkg::OP_SUB:
                        begin
                            if (dif_x[32] != dif_x[31])
                            begin
                                acc_x_next    = dif_x[32] ? vap_pkg::S32_MIN : vap_pkg::S32_MAX;
                                push_item.sat = 1'b1;
                            end
                            else
                            begin
                                acc_x_next = dif_x[31:0];
                            end
                            if (dif_y[32] != dif_y[31])
                            begin
                                acc_y_next    = dif_y[32] ? vap_pkg::S32_MIN : vap_pkg::S32_MAX;
                                push_item.sat = 1'b1;
                            end
                            else
                            begin
                                acc_y_next = dif_y[31:0];
                            end
                        end
                        vap_pkg::OP_SCALE:
                        begin
                            push       = 1'b0;
                            state_next = F_MULX;
                        end
                        vap_pkg::OP_CLEAR:
                        begin
                            acc_x_next = '0;
                            acc_y_next = '0;
                        end
                        default:
                        begin
                            acc_x_next = acc_x_reg;
                        end
                    endcase
                    push_item.x = acc_x_next;
                    push_item.y = acc_y_next;
                end
            end
            F_MULX:
            begin
                state_next = F_MULY;
            end
            F_MULY:
            begin
                state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (!full)
                begin
                    push = 1'b1;
                    if (shr_x[63:31] != {33{shr_x[63]}})
                    begin
                        acc_x_next    = shr_x[63] ? vap_pkg::S32_MIN : vap_pkg::S32_MAX;
                        push_item.sat = 1'b1;
                    end
                    else
                    begin
                        acc_x_next = shr_x[31:0];
                    end
                    if (shr_y[63:31] != {33{shr_y[63]}})
                    begin
                        acc_y_next    = shr_y[63] ? vap_pkg::S32_MIN : vap_pkg::S32_MAX;
                        push_item.sat = 1'b1;
                    end
                    else
                    begin
                        acc_y_next = shr_y[31:0];
                    end
                    push_item.x = acc_x_next;
                    push_item.y = acc_y_next;
                    state_next  = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            acc_x_reg <= '0;
            acc_y_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            acc_x_reg <= acc_x_next;
            acc_y_reg <= acc_y_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sf_reg <= cmd.scale_factor;
        end
        if (state_reg == F_MULX)
        begin
            px_reg <= prod_x;
        end
        if (state_reg == F_MULY)
        begin
            py_reg <= prod_y;
        end
    end

endmodule

// ----- hw/rtl/vap_queue.sv -----
module vap_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  vap_pkg::vec_item_t  push_item,
    output logic                full,
    input  logic                pop,
    output vap_pkg::vec_item_t  pop_item,
    output logic                empty
);

    localparam int DEPTH = vap_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    vap_pkg::vec_item_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- hw/rtl/vap_back.sv -----
module vap_back #(
    parameter int CORDIC_STEPS = vap_pkg::CORDIC_STEPS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                empty,
    input  vap_pkg::vec_item_t  pop_item,
    output logic                pop,
    vap_out_if.source           res
);

    localparam int CW     = vap_pkg::CORDIC_W;
    localparam int GB     = vap_pkg::GUARD_BITS;
    localparam int DW     = vap_pkg::DATA_W;
    localparam int HI_W   = CW - 32;
    localparam int SUM_W  = HI_W + 33;
    localparam int STEP_W = $clog2(CORDIC_STEPS);
    localparam int M_W    = SUM_W + 1 - GB;

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_ITER = 3'd1;
    localparam logic [2:0] B_MLO  = 3'd2;
    localparam logic [2:0] B_MHI  = 3'd3;
    localparam logic [2:0] B_DEG  = 3'd4;
    localparam logic [2:0] B_FIN  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic signed [CW-1:0] cx_reg, cy_reg;
    logic [vap_pkg::TURN_W-1:0] z_reg;
    logic zero_reg;
    vap_pkg::vec_item_t item_reg;
    logic [63:0] prod_reg;
    logic [SUM_W-1:0] sum_reg;

    logic out_valid_reg, out_valid_next;
    logic signed [DW-1:0] out_x_reg, out_y_reg;
    logic [DW-1:0] out_mag_reg;
    logic [vap_pkg::ANGLE_W-1:0] out_deg_reg;
    logic out_sat_reg;

    logic signed [CW-1:0] ld_x, ld_y, dx, dy;
    logic [vap_pkg::TURN_W-1:0] atan_val;
    logic y_pos;
    logic [SUM_W-1:0] hi_prod;
    logic [SUM_W:0] mag_rnd;
    logic [M_W-1:0] mag_full;
    logic [DW-1:0] mag_val;
    logic [42:0] deg_rnd;
    logic [10:0] deg_full;
    logic [vap_pkg::ANGLE_W-1:0] deg_val;
    logic fin_write;

    assign pop = (state_reg == B_IDLE) && !empty;

    assign ld_x = {{(CW - DW - GB){pop_item.x[DW-1]}}, pop_item.x, {GB{1'b0}}};
    assign ld_y = {{(CW - DW - GB){pop_item.y[DW-1]}}, pop_item.y, {GB{1'b0}}};

    // one vectoring micro-rotation per cycle
    assign dx       = cy_reg >>> step_reg;
    assign dy       = cx_reg >>> step_reg;
    assign y_pos    = !cy_reg[CW-1] && (|cy_reg);
    assign atan_val = vap_pkg::atan_turns(5'(step_reg));

    assign hi_prod  = SUM_W'(cx_reg[CW-1:32]) * SUM_W'(vap_pkg::INV_GAIN_Q32);

    assign mag_rnd  = {1'b0, sum_reg} + ((SUM_W + 1)'(1) << (GB - 1));
    assign mag_full = mag_rnd[SUM_W:GB];
    assign mag_val  = (|mag_full[M_W-1:DW]) ? {DW{1'b1}} : mag_full[DW-1:0];

    assign deg_rnd  = {1'b0, prod_reg[41:0]} + 43'h0_8000_0000;
    assign deg_full = deg_rnd[42:32];
    assign deg_val  = (deg_full >= 11'(vap_pkg::FULL_TURN_DEG)) ? '0 : deg_full[8:0];

    assign fin_write = (state_reg == B_FIN) && (!out_valid_reg || res.ready);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (!empty)
                begin
                    state_next = B_ITER;
                    step_next  = '0;
                end
            end
            B_ITER:
            begin
                if (step_reg == STEP_W'(CORDIC_STEPS - 1))
                begin
                    state_next = B_MLO;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            B_MLO:   state_next = B_MHI;
            B_MHI:   state_next = B_DEG;
            B_DEG:   state_next = B_FIN;
            B_FIN:
            begin
                if (fin_write)
                begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fin_write)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                if (pop)
                begin
                    item_reg <= pop_item;
                    zero_reg <= (pop_item.x == '0) && (pop_item.y == '0);
                    // left half plane: mirror through origin, start at half a turn
                    if (pop_item.x[DW-1])
                    begin
                        cx_reg <= -ld_x;
                        cy_reg <= -ld_y;
                        z_reg  <= vap_pkg::HALF_TURN;
                    end
                    else
                    begin
                        cx_reg <= ld_x;
                        cy_reg <= ld_y;
                        z_reg  <= '0;
                    end
                end
            end
            B_ITER:
            begin
                if (y_pos)
                begin
                    cx_reg <= cx_reg + dx;
                    cy_reg <= cy_reg - dy;
                    z_reg  <= z_reg + atan_val;
                end
                else
                begin
                    cx_reg <= cx_reg - dx;
                    cy_reg <= cy_reg + dy;
                    z_reg  <= z_reg - atan_val;
                end
            end
            B_MLO:
            begin
                prod_reg <= {32'b0, cx_reg[31:0]} * {32'b0, vap_pkg::INV_GAIN_Q32};
            end
            B_MHI:
            begin
                sum_reg <= hi_prod + SUM_W'(prod_reg[63:32]);
            end
            B_DEG:
            begin
                prod_reg <= {32'b0, z_reg} * 64'(vap_pkg::FULL_TURN_DEG);
            end
            default:
            begin
                prod_reg <= prod_reg;
            end
        endcase
        if (fin_write)
        begin
            out_x_reg   <= item_reg.x;
            out_y_reg   <= item_reg.y;
            out_sat_reg <= item_reg.sat;
            out_mag_reg <= zero_reg ? '0 : mag_val;
            out_deg_reg <= zero_reg ? '0 : deg_val;
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.vec_x         = out_x_reg;
    assign res.vec_y         = out_y_reg;
    assign res.magnitude     = out_mag_reg;
    assign res.angle_degrees = out_deg_reg;
    assign res.saturated     = out_sat_reg;

endmodule

// ----- hw/rtl/vap_checker.sv -----
`include "vector2_accumulator_polar_top_macros.svh"

module vap_props (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                res_valid,
    input logic                                res_ready,
    input logic signed [vap_pkg::DATA_W-1:0]   vec_x,
    input logic signed [vap_pkg::DATA_W-1:0]   vec_y,
    input logic [vap_pkg::DATA_W-1:0]          magnitude,
    input logic [vap_pkg::ANGLE_W-1:0]         angle_degrees,
    input logic                                saturated
);

    logic                                          res_stall;
    logic [3*vap_pkg::DATA_W+vap_pkg::ANGLE_W:0]   res_payload;
    logic                                          angle_ok;
    logic                                          zero_vec;
    logic                                          polar_zero;

    assign res_stall   = res_valid && !res_ready;
    assign res_payload = {vec_x, vec_y, magnitude, angle_degrees, saturated};
    assign angle_ok    = angle_degrees < vap_pkg::FULL_TURN_DEG;
    assign zero_vec    = res_valid && (vec_x == '0) && (vec_y == '0);
    assign polar_zero  = (magnitude == '0) && (angle_degrees == '0);

    // stalled result transaction keeps valid
    `VAP_ASSERT_NEXT(a_res_hold, clk, rst_n, res_stall, res_valid, "result dropped while stalled")

    // stalled result transaction keeps its payload
    `VAP_ASSERT_NEXT(a_res_stable, clk, rst_n, res_stall, $stable(res_payload), "payload changed")

    // wrapped angle never reaches a full turn
    `VAP_ASSERT_NOW(a_angle_range, clk, rst_n, res_valid, angle_ok, "angle out of range")

    // origin has no length and no direction
    `VAP_ASSERT_NOW(a_zero_polar, clk, rst_n, zero_vec, polar_zero, "zero vector with polar form")

endmodule

bind vector2_accumulator_polar_top vap_props u_vap_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .res_valid     (res.valid),
    .res_ready     (res.ready),
    .vec_x         (res.vec_x),
    .vec_y         (res.vec_y),
    .magnitude     (res.magnitude),
    .angle_degrees (res.angle_degrees),
    .saturated     (res.saturated)
);
